### hdl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// Hamming SEC codec package
// Shared widths, codes, payload types and position helpers for the codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // Field widths.
  localparam int MAX_DATA_BYTES = 7;
  localparam int DATA_W         = 8 * MAX_DATA_BYTES;
  localparam int CODE_W         = 62;
  localparam int SYN_W          = 6;
  localparam int CFG_W          = 3;
  localparam int ADDR_W         = 3;
  localparam int PDATA_W        = 32;

  // Operation codes.
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // Register index (word address bit).
  localparam logic REG_DATA_BYTES = 1'b0;

  // Reset value of the row length register.
  localparam logic [CFG_W-1:0] DATA_BYTES_RST = 3'd4;

  // One input transfer.
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data_in;
    logic [CODE_W-1:0] code_in;
  } cmd_t;

  // One result transfer.
  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic [DATA_W-1:0] data_out;
    logic [SYN_W-1:0]  syndrome;
    logic              corrected;
    logic              uncorrectable;
  } res_t;

  // True when a codeword position is a check bit position.
  function automatic bit is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Slot of a data position among the data positions, counted from 0.
  function automatic int data_slot(input int p);
    return p - $clog2(p + 1) - 1;
  endfunction

  // Codeword length for a row of m bytes.
  function automatic logic [SYN_W-1:0] code_len(input logic [CFG_W-1:0] m);
    logic [SYN_W-1:0] n;
    unique case (m)
      3'd0:    n = 6'd0;
      3'd1:    n = 6'd12;
      3'd2:    n = 6'd21;
      3'd3:    n = 6'd29;
      3'd4:    n = 6'd38;
      3'd5:    n = 6'd46;
      3'd6:    n = 6'd54;
      default: n = 6'd62;
    endcase
    return n;
  endfunction

  // Bit distance between the used data bytes and the top of the data field.
  function automatic logic [SYN_W-1:0] align_shift(input logic [CFG_W-1:0] m);
    logic [CFG_W-1:0] unused;
    unused = 3'd7 - m;
    return {unused, 3'b000};
  endfunction

endpackage

### hdl/hamming_sec_codec_top.sv
// ----------------------------------------------------------------------------
// Hamming SEC codec top level
// Encodes a row of data bytes into a single-error-correcting codeword, or
// checks and repairs a received codeword and extracts its data bytes.
// ----------------------------------------------------------------------------
// Pipeline: an accepted command passes one input register and then one
// result register before its result strobes on done.
// Throughput: one command per cycle; busy stays low, so start is never
// refused and results follow back to back.
// Reset: rst clears both pipeline valid flags and sets data_bytes to 4.
// ----------------------------------------------------------------------------
module hamming_sec_codec_top (
  input  logic                         clk,
  input  logic                         rst,
  // Command channel
  input  logic                         start,
  output logic                         busy,
  input  hsc_pkg::cmd_t                cmd,
  // Result channel
  output logic                         done,
  output hsc_pkg::res_t                res,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [hsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [hsc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int DW = hsc_pkg::DATA_W;
  localparam int CW = hsc_pkg::CODE_W;
  localparam int SW = hsc_pkg::SYN_W;

  // Configuration register and input stage.
  logic [hsc_pkg::CFG_W-1:0] data_bytes;
  logic                      in_valid;
  hsc_pkg::cmd_t             in_cmd;
  logic [SW-1:0]             in_len;
  logic [SW-1:0]             in_shift;

  // Combinational datapath.
  logic [DW-1:0] aligned_in;
  logic [CW-1:0] enc_data;
  logic [CW-1:0] len_mask;
  logic [CW-1:0] rx_code;
  logic [CW-1:0] syn_src;
  logic [SW-1:0] syn;
  logic          syn_nz;
  logic          syn_in_range;
  logic [CW-1:0] flip_vec;
  logic [CW-1:0] fixed_code;
  logic [DW-1:0] aligned_out;
  logic [CW-1:0] enc_code;
  hsc_pkg::res_t res_next;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_bytes <= hsc_pkg::DATA_BYTES_RST;
    end else if (psel && penable && pwrite && (paddr[2] == hsc_pkg::REG_DATA_BYTES)) begin
      data_bytes <= pwdata[hsc_pkg::CFG_W-1:0];
    end
  end

  // Register read data.
  always_comb begin
    prdata = '0;
    if (paddr[2] == hsc_pkg::REG_DATA_BYTES) begin
      prdata[hsc_pkg::CFG_W-1:0] = data_bytes;
    end
  end

  // Input stage: capture the command with the row geometry it uses.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_cmd   <= cmd;
      in_len   <= hsc_pkg::code_len(data_bytes);
      in_shift <= hsc_pkg::align_shift(data_bytes);
    end
  end

  // Left-align the data so the first data bit sits at the top of the field.
  assign aligned_in = in_cmd.data_in << in_shift;

  // Place data bits, build the length mask, and gather data on decode.
  for (genvar p = 1; p <= CW; p++) begin : g_pos
    assign len_mask[p-1] = (SW'(p) <= in_len);
    if (hsc_pkg::is_pow2(p)) begin : g_check
      assign enc_data[p-1] = 1'b0;
    end else begin : g_data
      localparam int K = hsc_pkg::data_slot(p);
      assign enc_data[p-1]      = aligned_in[DW-1-K];
      assign aligned_out[DW-1-K] = fixed_code[p-1];
    end
  end

  assign rx_code = in_cmd.code_in & len_mask;

  // One syndrome network serves both directions: on encode the check
  // positions are still zero, so it yields the check bits themselves.
  assign syn_src = (in_cmd.kind == hsc_pkg::KIND_DECODE) ? rx_code : enc_data;

  always_comb begin
    syn = '0;
    for (int p = 1; p <= CW; p++) begin
      if (syn_src[p-1]) begin
        syn = syn ^ SW'(p);
      end
    end
  end

  assign syn_nz       = (syn != '0);
  assign syn_in_range = (syn <= in_len);

  // Single-bit repair at the position the syndrome names.
  always_comb begin
    for (int p = 1; p <= CW; p++) begin
      flip_vec[p-1] = syn_nz && syn_in_range && (syn == SW'(p));
    end
  end

  assign fixed_code = rx_code ^ flip_vec;

  // Insert the check bits into the encoded word.
  always_comb begin
    enc_code = enc_data;
    for (int j = 0; j < SW; j++) begin
      enc_code[(1 << j) - 1] = syn[j];
    end
  end

  // Result fields; the unused direction reads as zero.
  always_comb begin
    res_next = '0;
    if (in_cmd.kind == hsc_pkg::KIND_DECODE) begin
      res_next.data_out      = aligned_out >> in_shift;
      res_next.syndrome      = syn;
      res_next.corrected     = syn_nz && syn_in_range;
      res_next.uncorrectable = syn_nz && !syn_in_range;
    end else begin
      res_next.code_out = enc_code;
    end
  end

  // Result stage: each result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      res <= res_next;
    end
  end

endmodule

### hdl/hsc_checker.sv
// ----------------------------------------------------------------------------
// Hamming SEC codec port checker
// Watches the top level's ports for timing and result consistency.
// ----------------------------------------------------------------------------
module hsc_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input hsc_pkg::res_t res
);

  // Every accepted command yields a result on done.
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted command produced no result");

  // No result appears without an earlier accepted command.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result transfer without a command");

  // Repair and failure flags never rise together.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.corrected && res.uncorrectable))
    else $error("corrected and uncorrectable both set");

  // A clean syndrome means no repair and no failure.
  a_zero_syn: assert property (@(posedge clk) disable iff (rst)
    (done && (res.syndrome == '0)) |-> (!res.corrected && !res.uncorrectable))
    else $error("flags set with zero syndrome");

  // A decode result with a repair or failure flag carries no encoded word.
  a_decode_code: assert property (@(posedge clk) disable iff (rst)
    (done && (res.corrected || res.uncorrectable)) |-> (res.code_out == '0))
    else $error("decode result carries a codeword");

endmodule

bind hamming_sec_codec_top hsc_checker u_hsc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
